@@ rtl/core/dmw_pkg.sv @@
// Shared types, sizes and codes of the displacement map warp.
// Used by every module of the block but dmw_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dmw_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;
	localparam int TABLE_WIDTH   = 2 * SCREEN_WIDTH;
	localparam int TABLE_HEIGHT  = 2 * SCREEN_HEIGHT;
	localparam int TABLE_DEPTH   = TABLE_WIDTH * TABLE_HEIGHT;
	localparam int IMAGE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int TADDR_W       = $clog2(TABLE_DEPTH);
	localparam int IADDR_W       = $clog2(IMAGE_DEPTH);
	localparam int IX_W          = $clog2(SCREEN_WIDTH);
	localparam int IY_W          = $clog2(SCREEN_HEIGHT);

	localparam int COL_W  = 10;
	localparam int ROW_W  = 9;
	localparam int BYTE_W = 8;
	localparam int LEFT_W = 9;
	localparam int TOP_W  = 8;
	localparam int TCOL_W = COL_W + 1;
	localparam int TROW_W = ROW_W + 1;
	localparam int SX_W   = COL_W + 2;
	localparam int SY_W   = ROW_W + 2;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [LEFT_W-1:0] XLEFT_RST = LEFT_W'(160);
	localparam logic [TOP_W-1:0]  XTOP_RST  = TOP_W'(240);
	localparam logic [LEFT_W-1:0] YLEFT_RST = LEFT_W'(320);
	localparam logic [TOP_W-1:0]  YTOP_RST  = TOP_W'(120);

	typedef enum logic [1:0] {
		OP_LOAD_H   = 2'd0,
		OP_LOAD_V   = 2'd1,
		OP_LOAD_IMG = 2'd2,
		OP_RENDER   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_XLEFT = 2'd0,
		REG_XTOP  = 2'd1,
		REG_YLEFT = 2'd2,
		REG_YTOP  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LEFT_W-1:0] xleft;
		logic [TOP_W-1:0]  xtop;
		logic [LEFT_W-1:0] yleft;
		logic [TOP_W-1:0]  ytop;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [BYTE_W-1:0] value;
	} item_t;

	// table addresses and range flags
	typedef struct packed {
		item_t              item;
		logic [TADDR_W-1:0] haddr;
		logic [TADDR_W-1:0] vaddr;
		logic               hok;
		logic               vok;
		logic               scr_ok;
	} taddr_t;

	// source position for the image access
	typedef struct packed {
		item_t           item;
		logic [IX_W-1:0] ix;
		logic [IY_W-1:0] iy;
		logic            rd_ok;
		logic            wr_ok;
	} src_t;

endpackage
`default_nettype wire

@@ rtl/core/dmw_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dmw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/dmw_addr.sv @@
// Stages 1-2: window offsets, range checks and table address multiply.
// Depends on dmw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmw_addr (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dmw_pkg::cfg_t  cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire dmw_pkg::item_t in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output dmw_pkg::taddr_t     out_data
);

	logic                        v_s1, v_s2;
	logic                        rdy1, rdy2, adv1, adv2;
	logic                        is_render;
	logic [dmw_pkg::TCOL_W-1:0]  hc, vc;
	logic [dmw_pkg::TROW_W-1:0]  hr, vr;
	dmw_pkg::item_t              item_s1;
	logic [dmw_pkg::TCOL_W-1:0]  hc_s1, vc_s1;
	logic [dmw_pkg::TROW_W-1:0]  hr_s1, vr_s1;
	logic                        hok_s1, vok_s1, scr_ok_s1;
	dmw_pkg::taddr_t             data_s2;

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign adv1     = in_valid && rdy1;
	assign adv2     = v_s1 && rdy2;
	assign in_ready = rdy1;

	always_comb begin
		is_render = (in_item.op == dmw_pkg::OP_RENDER);
		hc = dmw_pkg::TCOL_W'(in_item.col);
		hr = dmw_pkg::TROW_W'(in_item.row);
		vc = dmw_pkg::TCOL_W'(in_item.col);
		vr = dmw_pkg::TROW_W'(in_item.row);
		if (is_render) begin
			hc = dmw_pkg::TCOL_W'(in_item.col) + dmw_pkg::TCOL_W'(cfg.xleft);
			hr = dmw_pkg::TROW_W'(in_item.row) + dmw_pkg::TROW_W'(cfg.xtop);
			vc = dmw_pkg::TCOL_W'(in_item.col) + dmw_pkg::TCOL_W'(cfg.yleft);
			vr = dmw_pkg::TROW_W'(in_item.row) + dmw_pkg::TROW_W'(cfg.ytop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			item_s1   <= in_item;
			hc_s1     <= hc;
			hr_s1     <= hr;
			vc_s1     <= vc;
			vr_s1     <= vr;
			hok_s1    <= int'(hc) < dmw_pkg::TABLE_WIDTH && int'(hr) < dmw_pkg::TABLE_HEIGHT;
			vok_s1    <= int'(vc) < dmw_pkg::TABLE_WIDTH && int'(vr) < dmw_pkg::TABLE_HEIGHT;
			scr_ok_s1 <= int'(in_item.col) < dmw_pkg::SCREEN_WIDTH
				&& int'(in_item.row) < dmw_pkg::SCREEN_HEIGHT;
		end
		if (adv2) begin
			data_s2.item   <= item_s1;
			data_s2.haddr  <= dmw_pkg::TADDR_W'(hr_s1) * dmw_pkg::TADDR_W'(dmw_pkg::TABLE_WIDTH)
				+ dmw_pkg::TADDR_W'(hc_s1);
			data_s2.vaddr  <= dmw_pkg::TADDR_W'(vr_s1) * dmw_pkg::TADDR_W'(dmw_pkg::TABLE_WIDTH)
				+ dmw_pkg::TADDR_W'(vc_s1);
			data_s2.hok    <= hok_s1;
			data_s2.vok    <= vok_s1;
			data_s2.scr_ok <= scr_ok_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule
`default_nettype wire

@@ rtl/core/dmw_shift.sv @@
// Stages 3-4: shift table access (load or read) and displaced source position.
// Depends on dmw_pkg and dmw_ram.
`timescale 1ns / 1ps
`default_nettype none
module dmw_shift (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire dmw_pkg::taddr_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output dmw_pkg::src_t        out_data
);

	logic                        v_s3, v_s4;
	logic                        rdy3, rdy4, adv3, adv4;
	logic                        h_we, v_we;
	logic [dmw_pkg::BYTE_W-1:0]  hq_s3, vq_s3;
	dmw_pkg::item_t              item_s3;
	logic                        hok_s3, vok_s3, scr_ok_s3;
	logic [dmw_pkg::BYTE_W-1:0]  sx, sy;
	logic signed [dmw_pkg::SX_W-1:0] srcx;
	logic signed [dmw_pkg::SY_W-1:0] srcy;
	logic                        is_render, in_img;
	dmw_pkg::src_t               data_s4;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign adv3     = in_valid && rdy3;
	assign adv4     = v_s3 && rdy4;
	assign in_ready = rdy3;

	assign h_we = adv3 && in_data.item.op == dmw_pkg::OP_LOAD_H && in_data.hok;
	assign v_we = adv3 && in_data.item.op == dmw_pkg::OP_LOAD_V && in_data.vok;

	dmw_ram #(.WIDTH(dmw_pkg::BYTE_W), .DEPTH(dmw_pkg::TABLE_DEPTH)) u_htab (
		.clk   (clk),
		.we    (h_we),
		.waddr (in_data.haddr),
		.wdata (in_data.item.value),
		.re    (adv3),
		.raddr (in_data.haddr),
		.rdata (hq_s3)
	);

	dmw_ram #(.WIDTH(dmw_pkg::BYTE_W), .DEPTH(dmw_pkg::TABLE_DEPTH)) u_vtab (
		.clk   (clk),
		.we    (v_we),
		.waddr (in_data.vaddr),
		.wdata (in_data.item.value),
		.re    (adv3),
		.raddr (in_data.vaddr),
		.rdata (vq_s3)
	);

	always_comb begin
		sx        = hok_s3 ? hq_s3 : '0;
		sy        = vok_s3 ? vq_s3 : '0;
		srcx      = $signed(dmw_pkg::SX_W'(item_s3.col)) + dmw_pkg::SX_W'($signed(sx));
		srcy      = $signed(dmw_pkg::SY_W'(item_s3.row)) + dmw_pkg::SY_W'($signed(sy));
		is_render = (item_s3.op == dmw_pkg::OP_RENDER);
		in_img    = srcx >= 0 && int'(srcx) < dmw_pkg::SCREEN_WIDTH
			&& srcy >= 0 && int'(srcy) < dmw_pkg::SCREEN_HEIGHT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy3) v_s3 <= in_valid;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			item_s3   <= in_data.item;
			hok_s3    <= in_data.hok;
			vok_s3    <= in_data.vok;
			scr_ok_s3 <= in_data.scr_ok;
		end
		if (adv4) begin
			data_s4.item  <= item_s3;
			data_s4.ix    <= is_render ? dmw_pkg::IX_W'(srcx) : dmw_pkg::IX_W'(item_s3.col);
			data_s4.iy    <= is_render ? dmw_pkg::IY_W'(srcy) : dmw_pkg::IY_W'(item_s3.row);
			data_s4.rd_ok <= is_render && scr_ok_s3 && in_img;
			data_s4.wr_ok <= item_s3.op == dmw_pkg::OP_LOAD_IMG && scr_ok_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = data_s4;

endmodule
`default_nettype wire

@@ rtl/core/dmw_fetch.sv @@
// Stages 5-6: image address multiply, image access and the result register.
// Depends on dmw_pkg and dmw_ram.
`timescale 1ns / 1ps
`default_nettype none
module dmw_fetch (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire dmw_pkg::src_t              in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            out_we,
	output logic [dmw_pkg::COL_W-1:0]       out_col,
	output logic [dmw_pkg::ROW_W-1:0]       out_row,
	output logic [dmw_pkg::BYTE_W-1:0]      out_pixel
);

	logic                        v_s5, v_s6;
	logic                        rdy5, rdy6, adv5, adv6;
	dmw_pkg::item_t              item_s5;
	logic [dmw_pkg::IADDR_W-1:0] iaddr_s5;
	logic                        rd_ok_s5, wr_ok_s5;
	logic                        we_s6;
	logic [dmw_pkg::COL_W-1:0]   col_s6;
	logic [dmw_pkg::ROW_W-1:0]   row_s6;
	logic [dmw_pkg::BYTE_W-1:0]  q_s6;
	logic                        img_we;

	assign rdy6     = !v_s6 || out_ready;
	assign rdy5     = !v_s5 || rdy6;
	assign adv5     = in_valid && rdy5;
	assign adv6     = v_s5 && rdy6;
	assign in_ready = rdy5;
	assign img_we   = adv6 && wr_ok_s5;

	dmw_ram #(.WIDTH(dmw_pkg::BYTE_W), .DEPTH(dmw_pkg::IMAGE_DEPTH)) u_img (
		.clk   (clk),
		.we    (img_we),
		.waddr (iaddr_s5),
		.wdata (item_s5.value),
		.re    (adv6),
		.raddr (iaddr_s5),
		.rdata (q_s6)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy5) v_s5 <= in_valid;
			// loads end here: only renders give a result
			if (rdy6) v_s6 <= v_s5 && item_s5.op == dmw_pkg::OP_RENDER;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			item_s5  <= in_data.item;
			iaddr_s5 <= dmw_pkg::IADDR_W'(in_data.iy)
				* dmw_pkg::IADDR_W'(dmw_pkg::SCREEN_WIDTH) + dmw_pkg::IADDR_W'(in_data.ix);
			rd_ok_s5 <= in_data.rd_ok;
			wr_ok_s5 <= in_data.wr_ok;
		end
		if (adv6) begin
			we_s6  <= rd_ok_s5;
			col_s6 <= item_s5.col;
			row_s6 <= item_s5.row;
		end
	end

	assign out_valid = v_s6;
	assign out_we    = we_s6;
	assign out_col   = col_s6;
	assign out_row   = row_s6;
	assign out_pixel = we_s6 ? q_s6 : '0;

endmodule
`default_nettype wire

@@ rtl/core/displacement_map_warp_top.sv @@
// Top level of the displacement map warp: APB window registers and the
// six-stage pipeline. Depends on dmw_pkg, dmw_addr, dmw_shift, dmw_fetch.
//
//   channel   handshake                   payload
//   request   req_valid / req_ready       opcode, col, row, load_value
//   result    rsp_valid / rsp_ready       write_enable, dest_col, dest_row, pixel
//   config    APB psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// One request per cycle while results are taken; a render result is registered
// at the outputs in the result register of the last stage, the image read.
// Stages: window add, table address multiply, shift table read, source add,
// image address multiply, image read. Loads write their memory in flight and
// give no result. No clearing pass after reset: window registers return to
// their defaults and the pipeline empties. A stalled result holds each stage
// that is full; empty stages still take new requests.
`timescale 1ns / 1ps
`default_nettype none
module displacement_map_warp_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [dmw_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [dmw_pkg::PDATA_W-1:0]    pwdata,
	output logic      [dmw_pkg::PDATA_W-1:0]    prdata,
	output logic                                pready,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire logic [1:0]                     opcode,
	input  wire logic [dmw_pkg::COL_W-1:0]      col,
	input  wire logic [dmw_pkg::ROW_W-1:0]      row,
	input  wire logic [dmw_pkg::BYTE_W-1:0]     load_value,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output logic                                write_enable,
	output logic [dmw_pkg::LEFT_W-1:0]          dest_col,
	output logic [dmw_pkg::TOP_W-1:0]           dest_row,
	output logic [dmw_pkg::BYTE_W-1:0]          pixel
);

	dmw_pkg::cfg_t     cfg_q;
	dmw_pkg::reg_idx_t reg_idx;
	logic              wr_en;
	dmw_pkg::item_t    req_item;
	logic              a_valid, a_ready, s_valid, s_ready;
	dmw_pkg::taddr_t   a_data;
	dmw_pkg::src_t     s_data;
	logic [dmw_pkg::COL_W-1:0] rsp_col;
	logic [dmw_pkg::ROW_W-1:0] rsp_row;

	assign pready  = 1'b1;
	assign reg_idx = dmw_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.xleft <= dmw_pkg::XLEFT_RST;
			cfg_q.xtop  <= dmw_pkg::XTOP_RST;
			cfg_q.yleft <= dmw_pkg::YLEFT_RST;
			cfg_q.ytop  <= dmw_pkg::YTOP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				dmw_pkg::REG_XLEFT: cfg_q.xleft <= pwdata[dmw_pkg::LEFT_W-1:0];
				dmw_pkg::REG_XTOP:  cfg_q.xtop  <= pwdata[dmw_pkg::TOP_W-1:0];
				dmw_pkg::REG_YLEFT: cfg_q.yleft <= pwdata[dmw_pkg::LEFT_W-1:0];
				dmw_pkg::REG_YTOP:  cfg_q.ytop  <= pwdata[dmw_pkg::TOP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dmw_pkg::REG_XLEFT: prdata = dmw_pkg::PDATA_W'(cfg_q.xleft);
			dmw_pkg::REG_XTOP:  prdata = dmw_pkg::PDATA_W'(cfg_q.xtop);
			dmw_pkg::REG_YLEFT: prdata = dmw_pkg::PDATA_W'(cfg_q.yleft);
			dmw_pkg::REG_YTOP:  prdata = dmw_pkg::PDATA_W'(cfg_q.ytop);
			default:            prdata = '0;
		endcase
	end

	assign req_item.op    = dmw_pkg::op_t'(opcode);
	assign req_item.col   = col;
	assign req_item.row   = row;
	assign req_item.value = load_value;

	dmw_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.in_item   (req_item),
		.out_valid (a_valid),
		.out_ready (a_ready),
		.out_data  (a_data)
	);

	dmw_shift u_shift (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_valid),
		.in_ready  (a_ready),
		.in_data   (a_data),
		.out_valid (s_valid),
		.out_ready (s_ready),
		.out_data  (s_data)
	);

	dmw_fetch u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.in_data   (s_data),
		.out_valid (rsp_valid),
		.out_ready (rsp_ready),
		.out_we    (write_enable),
		.out_col   (rsp_col),
		.out_row   (rsp_row),
		.out_pixel (pixel)
	);

	assign dest_col = rsp_col[dmw_pkg::LEFT_W-1:0];
	assign dest_row = rsp_row[dmw_pkg::TOP_W-1:0];

endmodule
`default_nettype wire

@@ rtl/core/dmw_checker.sv @@
// Port-level checks on the displacement map warp, bound to the top level.
// Depends on dmw_pkg and displacement_map_warp_top.
`timescale 1ns / 1ps
`default_nettype none
module dmw_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic                        write_enable,
	input wire logic [dmw_pkg::LEFT_W-1:0]  dest_col,
	input wire logic [dmw_pkg::TOP_W-1:0]   dest_row,
	input wire logic [dmw_pkg::BYTE_W-1:0]  pixel
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(write_enable) && $stable(dest_col)
			&& $stable(dest_row) && $stable(pixel))
		else $error("result changed while stalled");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !write_enable |-> pixel == '0)
		else $error("pixel not zero without write");

	a_write_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && write_enable |-> int'(dest_col) < dmw_pkg::SCREEN_WIDTH
			&& int'(dest_row) < dmw_pkg::SCREEN_HEIGHT)
		else $error("write outside the screen");

	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("result right after reset");

endmodule

bind displacement_map_warp_top dmw_checker u_dmw_checker (.*);
`default_nettype wire

@@ tb/tb_displacement_map_warp_top.sv @@
// Testbench for displacement_map_warp_top: drives load and render requests and
// checks every result against a shadow copy of the tables, image and windows.
// Depends on dmw_pkg and the displacement_map_warp_top RTL.
`timescale 1ns / 1ps
module tb_displacement_map_warp_top;
	import dmw_pkg::*;

	typedef struct packed {
		logic              we;
		logic [LEFT_W-1:0] col;
		logic [TOP_W-1:0]  row;
		logic [BYTE_W-1:0] px;
	} dest_pixel_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic [1:0]          opcode = '0;
	logic [COL_W-1:0]    col = '0;
	logic [ROW_W-1:0]    row = '0;
	logic [BYTE_W-1:0]   load_value = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic                write_enable;
	logic [LEFT_W-1:0]   dest_col;
	logic [TOP_W-1:0]    dest_row;
	logic [BYTE_W-1:0]   pixel;

	// shadow state
	logic [7:0] h_mem [TABLE_DEPTH];
	logic [7:0] v_mem [TABLE_DEPTH];
	logic [7:0] img_mem [IMAGE_DEPTH];
	bit         h_written [TABLE_DEPTH];
	bit         v_written [TABLE_DEPTH];
	bit         img_written [IMAGE_DEPTH];
	int         win_xleft = int'(XLEFT_RST);
	int         win_xtop  = int'(XTOP_RST);
	int         win_yleft = int'(YLEFT_RST);
	int         win_ytop  = int'(YTOP_RST);

	dest_pixel_t pending_pixels[$];

	int error_count = 0;
	int requests_counted = 0;
	int renders_sent = 0;
	int loads_ignored = 0;
	int pixels_written = 0;
	int pixels_skipped = 0;
	int window_settings = 1;
	int burst_left = 0;
	bit steady_sender = 1'b0;
	int holdoff_requests = 0;
	int patch_x, patch_y, patch_w, patch_h;

	displacement_map_warp_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.opcode       (opcode),
		.col          (col),
		.row          (row),
		.load_value   (load_value),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.write_enable (write_enable),
		.dest_col     (dest_col),
		.dest_row     (dest_row),
		.pixel        (pixel)
	);

	always #1 clk = ~clk;

	function automatic int table_shift(bit vert, int tc, int tr);
		logic [7:0] b;
		if (tc >= TABLE_WIDTH || tr >= TABLE_HEIGHT)
			return 0;
		b = vert ? v_mem[tr * TABLE_WIDTH + tc] : h_mem[tr * TABLE_WIDTH + tc];
		return int'($signed(b));
	endfunction

	// image index of the displaced source, -1 when nothing is written
	function automatic int source_index(int x, int y);
		int sx, sy;
		if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT)
			return -1;
		sx = x + table_shift(1'b0, win_xleft + x, win_xtop + y);
		sy = y + table_shift(1'b1, win_yleft + x, win_ytop + y);
		if (sx < 0 || sx >= SCREEN_WIDTH || sy < 0 || sy >= SCREEN_HEIGHT)
			return -1;
		return sy * SCREEN_WIDTH + sx;
	endfunction

	function automatic dest_pixel_t predict_warp(int x, int y);
		dest_pixel_t p;
		int idx;
		idx = source_index(x, y);
		p.we  = (idx >= 0);
		p.col = LEFT_W'(x);
		p.row = TOP_W'(y);
		p.px  = (idx >= 0) ? img_mem[idx] : '0;
		return p;
	endfunction

	function automatic logic [7:0] pick_shift();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 8'(int'($urandom_range(0, 6)) - 3);
			6, 7, 8: return 8'(int'($urandom_range(0, 48)) - 24);
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_req(op_t op, int c, int r, logic [7:0] v);
		int gap, idx;
		if (!steady_sender && burst_left <= 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid  <= 1'b1;
		opcode     <= op;
		col        <= COL_W'(c);
		row        <= ROW_W'(r);
		load_value <= v;
		do @(posedge clk); while (!req_ready);
		case (op)
			OP_LOAD_H, OP_LOAD_V: begin
				if (c < TABLE_WIDTH && r < TABLE_HEIGHT) begin
					idx = r * TABLE_WIDTH + c;
					if (op == OP_LOAD_H) begin
						h_mem[idx] = v;
						h_written[idx] = 1'b1;
					end else begin
						v_mem[idx] = v;
						v_written[idx] = 1'b1;
					end
					requests_counted++;
				end else
					loads_ignored++;
			end
			OP_LOAD_IMG: begin
				if (c < SCREEN_WIDTH && r < SCREEN_HEIGHT) begin
					idx = r * SCREEN_WIDTH + c;
					img_mem[idx] = v;
					img_written[idx] = 1'b1;
					requests_counted++;
				end else
					loads_ignored++;
			end
			default: begin
				pending_pixels.push_back(predict_warp(c, r));
				requests_counted++;
				renders_sent++;
			end
		endcase
	endtask

	// loads whatever the render would read that was never written, then renders
	task automatic render_pixel(int x, int y, logic [7:0] hv, logic [7:0] vv, logic [7:0] iv);
		int tc, tr, idx;
		if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT) begin
			tc = win_xleft + x;
			tr = win_xtop + y;
			if (tc < TABLE_WIDTH && tr < TABLE_HEIGHT && !h_written[tr * TABLE_WIDTH + tc])
				send_req(OP_LOAD_H, tc, tr, hv);
			tc = win_yleft + x;
			tr = win_ytop + y;
			if (tc < TABLE_WIDTH && tr < TABLE_HEIGHT && !v_written[tr * TABLE_WIDTH + tc])
				send_req(OP_LOAD_V, tc, tr, vv);
			idx = source_index(x, y);
			if (idx >= 0 && !img_written[idx])
				send_req(OP_LOAD_IMG, idx % SCREEN_WIDTH, idx / SCREEN_WIDTH, iv);
		end
		send_req(OP_RENDER, x, y, 8'($urandom));
	endtask

	task automatic apb_access(bit wr, reg_idx_t idx, logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'(4 * int'(idx));
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_check(reg_idx_t idx, int expected);
		logic [31:0] rdata;
		apb_access(1'b0, idx, '0, rdata);
		if (rdata !== 32'(expected)) begin
			$display("%0t register %s readback: expected %0h, got %0h",
				$time, idx.name(), expected, rdata);
			error_count++;
		end
	endtask

	task automatic write_reg(reg_idx_t idx, int value, int mask);
		logic [31:0] rdata;
		apb_access(1'b1, idx, {$urandom} & ~32'(mask) | 32'(value & mask), rdata);
		read_check(idx, value & mask);
	endtask

	task automatic drain_pipeline();
		req_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic program_window(int xl, int xt, int yl, int yt);
		drain_pipeline();
		write_reg(REG_XLEFT, xl, 9'h1FF);
		write_reg(REG_XTOP, xt, 8'hFF);
		write_reg(REG_YLEFT, yl, 9'h1FF);
		write_reg(REG_YTOP, yt, 8'hFF);
		win_xleft = xl & 9'h1FF;
		win_xtop  = xt & 8'hFF;
		win_yleft = yl & 9'h1FF;
		win_ytop  = yt & 8'hFF;
		window_settings++;
	endtask

	task automatic new_patch();
		patch_w = $urandom_range(1, 24);
		patch_h = $urandom_range(1, 24);
		case ($urandom_range(0, 3))
			0: patch_x = 0;
			1: patch_x = SCREEN_WIDTH - patch_w;
			default: patch_x = $urandom_range(0, SCREEN_WIDTH - patch_w);
		endcase
		case ($urandom_range(0, 3))
			0: patch_y = 0;
			1: patch_y = SCREEN_HEIGHT - patch_h;
			default: patch_y = $urandom_range(0, SCREEN_HEIGHT - patch_h);
		endcase
	endtask

	task automatic run_random_traffic(int n);
		int start_count, k, x, y, tc, tr, lim_c, lim_r, c, r;
		op_t op;
		start_count = requests_counted;
		new_patch();
		while (requests_counted - start_count < n) begin
			k = $urandom_range(0, 99);
			x = patch_x + $urandom_range(0, patch_w - 1);
			y = patch_y + $urandom_range(0, patch_h - 1);
			if (k < 60)
				render_pixel(x, y, pick_shift(), pick_shift(), 8'($urandom));
			else if (k < 70) begin
				// rewrite a table entry that renders in this patch will read
				op = (k < 65) ? OP_LOAD_H : OP_LOAD_V;
				tc = (op == OP_LOAD_H) ? win_xleft + x : win_yleft + x;
				tr = (op == OP_LOAD_H) ? win_xtop + y : win_ytop + y;
				if (tc < TABLE_WIDTH && tr < TABLE_HEIGHT)
					send_req(op, tc, tr, pick_shift());
			end else if (k < 78)
				send_req(OP_LOAD_IMG, x, y, 8'($urandom));
			else if (k < 86)
				send_req(k[0] ? OP_LOAD_V : OP_LOAD_H, $urandom_range(0, TABLE_WIDTH - 1),
					$urandom_range(0, TABLE_HEIGHT - 1), 8'($urandom));
			else if (k < 98) begin
				// loads outside their store, renders off screen
				op = (k < 92) ? op_t'($urandom_range(0, 2)) : OP_RENDER;
				lim_c = (op == OP_LOAD_H || op == OP_LOAD_V) ? TABLE_WIDTH : SCREEN_WIDTH;
				lim_r = (op == OP_LOAD_H || op == OP_LOAD_V) ? TABLE_HEIGHT : SCREEN_HEIGHT;
				if ($urandom_range(0, 1)) begin
					c = $urandom_range(lim_c, 1023);
					r = $urandom_range(0, 511);
				end else begin
					c = $urandom_range(0, 1023);
					r = $urandom_range(lim_r, 511);
				end
				send_req(op, c, r, 8'($urandom));
			end else
				new_patch();
		end
	endtask

	task automatic test_reset_values();
		read_check(REG_XLEFT, int'(XLEFT_RST));
		read_check(REG_XTOP, int'(XTOP_RST));
		read_check(REG_YLEFT, int'(YLEFT_RST));
		read_check(REG_YTOP, int'(YTOP_RST));
	endtask

	task automatic test_directed_cases();
		render_pixel(0, 0, 8'h00, 8'h00, 8'hFF);
		render_pixel(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 8'h80, 8'h7F, 8'h00);
		render_pixel(SCREEN_WIDTH - 1, 0, 8'h01, 8'h00, 8'h55);
		render_pixel(0, SCREEN_HEIGHT - 1, 8'hFF, 8'h00, 8'hAA);
		render_pixel(5, 0, 8'h00, 8'hFF, 8'h11);
		send_req(OP_RENDER, 1023, 511, 8'hFF);
		send_req(OP_RENDER, SCREEN_WIDTH, 0, 8'h00);
		send_req(OP_RENDER, 0, SCREEN_HEIGHT, 8'h00);
		send_req(OP_LOAD_H, TABLE_WIDTH, 0, 8'h7F);
		send_req(OP_LOAD_V, 0, TABLE_HEIGHT, 8'h7F);
		send_req(OP_LOAD_IMG, SCREEN_WIDTH, 0, 8'h33);
		send_req(OP_LOAD_IMG, 1023, 511, 8'h33);
		send_req(OP_LOAD_IMG, 0, 0, 8'h00);
		render_pixel(0, 0, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_window_settings();
		program_window(0, 0, 0, 0);
		run_random_traffic(260);
		program_window(320, 240, 320, 240);
		run_random_traffic(260);
		// windows past the table read as zero shift
		program_window(511, 255, 511, 255);
		run_random_traffic(260);
		program_window(0, 255, 511, 0);
		run_random_traffic(200);
		program_window($urandom_range(0, 320), $urandom_range(0, 240),
			$urandom_range(0, 320), $urandom_range(0, 240));
		run_random_traffic(260);
	endtask

	task automatic test_backpressure();
		int i, x, y;
		new_patch();
		steady_sender = 1'b1;
		holdoff_requests++;
		for (i = 0; i < 150; i++) begin
			x = patch_x + $urandom_range(0, patch_w - 1);
			y = patch_y + $urandom_range(0, patch_h - 1);
			render_pixel(x, y, pick_shift(), pick_shift(), 8'($urandom));
		end
		steady_sender = 1'b0;
	endtask

	// result side: own stall pattern plus long hold-offs on request
	initial begin
		int mode, mode_left, stall_left, hold_left, served, phase;
		mode_left = 0;
		stall_left = 0;
		hold_left = 0;
		served = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if (served != holdoff_requests) begin
				served = holdoff_requests;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				if (mode_left <= 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					2: rsp_ready <= (phase % 3 != 0);
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							rsp_ready <= 1'b0;
						end else begin
							rsp_ready <= 1'b1;
							if ($urandom_range(0, 5) == 0)
								stall_left = $urandom_range(1, 12);
						end
					end
				endcase
			end
		end
	end

	task automatic report_field(string fname, logic [31:0] expv, logic [31:0] actv);
		$display("%0t mismatch %s: expected %0h, got %0h", $time, fname, expv, actv);
		error_count++;
	endtask

	always @(posedge clk) begin
		dest_pixel_t exp_px;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t unexpected result: expected none, got we=%0b col=%0d row=%0d px=%0h",
					$time, write_enable, dest_col, dest_row, pixel);
				error_count++;
			end else begin
				exp_px = pending_pixels.pop_front();
				if (write_enable !== exp_px.we)
					report_field("write_enable", exp_px.we, write_enable);
				if (dest_col !== exp_px.col)
					report_field("dest_col", exp_px.col, dest_col);
				if (dest_row !== exp_px.row)
					report_field("dest_row", exp_px.row, dest_row);
				if (pixel !== exp_px.px)
					report_field("pixel", exp_px.px, pixel);
				if (exp_px.we)
					pixels_written++;
				else
					pixels_skipped++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed_cases();
		run_random_traffic(300);
		test_window_settings();
		test_backpressure();
		drain_pipeline();
		repeat (8) @(posedge clk);
		$display("Covered %0d requests (%0d renders, %0d ignored loads) over %0d window settings,",
			requests_counted, renders_sent, loads_ignored, window_settings);
		$display("including a long result stall; %0d pixels written, %0d skipped.",
			pixels_written, pixels_skipped);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

@@ displacement_map_warp_top.f @@
rtl/core/dmw_pkg.sv
rtl/core/dmw_ram.sv
rtl/core/dmw_addr.sv
rtl/core/dmw_shift.sv
rtl/core/dmw_fetch.sv
rtl/core/displacement_map_warp_top.sv
rtl/core/dmw_checker.sv
tb/tb_displacement_map_warp_top.sv
